### src/sha256mh_pkg.sv
package sha256mh_pkg;

	localparam int HashWords = 8;
	localparam int Rounds    = 64;

	localparam logic [7:0] PadMark = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

	localparam logic [31:0] InitHash [HashWords] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] RoundK [Rounds] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

endpackage

### src/sha256_message_hasher_core.sv
// SHA-256 hasher taking one message byte per word on the slave stream and returning the
// 256-bit digest as one word on the master stream after the word marked with tlast. Bytes
// are taken at one per cycle, in the idle state only, into a 512-bit block register; the
// 64th byte of a block starts the round unit, which runs one round per cycle through every
// round and then folds the result into the chained hash; the block is not ready while
// padding, the rounds, the fold or the digest hand-off run. After the last word the padding
// bytes go through the same byte path at one per cycle, so the end of a message takes up
// to 72 pad bytes plus one or two compressions before the digest appears. The digest
// waits in its own output register; the next message may be taken in while it waits, and
// a second digest stalls only if the first is still not taken.
module sha256_message_hasher_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // has_byte
	input  logic         s_tlast,   // last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata    // digest_word_0 .. digest_word_7
);

	sha256mh_pkg::state_t state_q, state_d;

	logic [511:0] blk_q;
	logic [31:0]  chain_q [sha256mh_pkg::HashWords];
	logic [31:0]  var_q   [sha256mh_pkg::HashWords];
	logic [63:0]  len_q;
	logic [5:0]   pos_q;
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic         mark_q;
	logic         lenph_q;
	logic [255:0] dig_q;
	logic         m_tvalid_q;

	logic         place_en;
	logic [7:0]   place_byte;
	logic         add_len;
	logic         fin_set;
	logic         mark_set;
	logic         lenph_set;
	logic         round_en;
	logic         add_en;
	logic         out_en;

	logic [31:0]  w0, w1, w9, w14, w_next;
	logic [31:0]  t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];

	assign w_next = w0 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w9
		+ (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

	assign t1 = var_q[7] + (rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25))
		+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
		+ sha256mh_pkg::RoundK[rnd_q] + w0;
	assign t2 = (rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22))
		+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256mh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		place_en   = 1'b0;
		place_byte = s_tdata;
		add_len    = 1'b0;
		fin_set    = 1'b0;
		mark_set   = 1'b0;
		lenph_set  = 1'b0;
		round_en   = 1'b0;
		add_en     = 1'b0;
		out_en     = 1'b0;
		unique case (state_q)
			sha256mh_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					place_en = s_tuser;
					add_len  = s_tuser;
					fin_set  = s_tlast;
					if (s_tuser && pos_q == 6'd63) begin
						state_d = sha256mh_pkg::ST_ROUND;
					end else if (s_tlast) begin
						state_d = sha256mh_pkg::ST_PAD;
					end
				end
			end
			sha256mh_pkg::ST_PAD: begin
				place_en = 1'b1;
				priority if (!mark_q) begin
					place_byte = sha256mh_pkg::PadMark;
					mark_set   = 1'b1;
				end else if (lenph_q || pos_q == 6'd56) begin
					place_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
					lenph_set  = 1'b1;
				end else begin
					place_byte = 8'h00;
				end
				if (pos_q == 6'd63) begin
					state_d = sha256mh_pkg::ST_ROUND;
				end
			end
			sha256mh_pkg::ST_ROUND: begin
				round_en = 1'b1;
				if (rnd_q == 6'd63) begin
					state_d = sha256mh_pkg::ST_ADD;
				end
			end
			sha256mh_pkg::ST_ADD: begin
				add_en = 1'b1;
				priority if (lenph_q) begin
					state_d = sha256mh_pkg::ST_DONE;
				end else if (fin_q) begin
					state_d = sha256mh_pkg::ST_PAD;
				end else begin
					state_d = sha256mh_pkg::ST_IDLE;
				end
			end
			sha256mh_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_en  = 1'b1;
					state_d = sha256mh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256mh_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha256mh_pkg::HashWords; i++) begin
				chain_q[i] <= sha256mh_pkg::InitHash[i];
			end
			len_q      <= '0;
			pos_q      <= '0;
			rnd_q      <= '0;
			fin_q      <= 1'b0;
			mark_q     <= 1'b0;
			lenph_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (add_len) begin
				len_q <= len_q + 64'd8;
			end
			if (place_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (fin_set) begin
				fin_q <= 1'b1;
			end
			if (mark_set) begin
				mark_q <= 1'b1;
			end
			if (lenph_set) begin
				lenph_q <= 1'b1;
			end
			if (round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (add_en) begin
				for (int i = 0; i < sha256mh_pkg::HashWords; i++) begin
					chain_q[i] <= chain_q[i] + var_q[i];
				end
			end
			if (out_en) begin
				for (int i = 0; i < sha256mh_pkg::HashWords; i++) begin
					chain_q[i] <= sha256mh_pkg::InitHash[i];
				end
				len_q   <= '0;
				fin_q   <= 1'b0;
				mark_q  <= 1'b0;
				lenph_q <= 1'b0;
			end
			if (out_en) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			blk_q <= {blk_q[503:0], place_byte};
			if (pos_q == 6'd63) begin
				var_q <= chain_q;
			end
		end
		if (round_en) begin
			blk_q    <= {blk_q[479:0], w_next};
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
		if (out_en) begin
			for (int i = 0; i < sha256mh_pkg::HashWords; i++) begin
				dig_q[32*i +: 32] <= chain_q[i];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = dig_q;

	a_round_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256mh_pkg::ST_ROUND && rnd_q != 6'd63)
		|=> (state_q == sha256mh_pkg::ST_ROUND && rnd_q == $past(rnd_q) + 6'd1))
		else $error("round counter did not advance");

	a_add_after_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256mh_pkg::ST_ADD)
		|-> ($past(state_q) == sha256mh_pkg::ST_ROUND && $past(rnd_q) == 6'd63))
		else $error("chain update without 64 rounds");

	a_round_on_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(place_en && pos_q == 6'd63)
		|=> (state_q == sha256mh_pkg::ST_ROUND && rnd_q == 6'd0 && pos_q == 6'd0))
		else $error("full block did not start rounds");

	a_digest_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == sha256mh_pkg::ST_DONE))
		else $error("digest raised outside done state");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 400;
	localparam int WordTarget = 430;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} byte_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;   // data_byte
	logic         s_tuser = 1'b0; // has_byte
	logic         s_tlast = 1'b0; // last
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [255:0] m_tdata;        // digest_word_0 .. digest_word_7

	byte_word_t   pend_words[$];
	logic [255:0] digest_due[$];
	byte_word_t   shown_word;
	int           mismatches = 0;
	int           cycles = 0;
	int           gap_left = 0;
	int           burst_left = 1;
	int           ready_hold = 0;

	logic [31:0]  chain_h [sha256mh_pkg::HashWords];
	logic [31:0]  sched [16];
	logic [63:0]  bit_count;
	logic [5:0]   byte_pos;

	sha256_message_hasher_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < sha256mh_pkg::HashWords; i++) chain_h[i] = sha256mh_pkg::InitHash[i];
		bit_count = '0;
		byte_pos = '0;
	endtask

	task automatic compress_block();
		logic [31:0] v [8];
		logic [31:0] w, w15, w2, s0, s1, ch, mj, t1, t2;
		for (int i = 0; i < 8; i++) v[i] = chain_h[i];
		for (int t = 0; t < sha256mh_pkg::Rounds; t++) begin
			if (t < 16) begin
				w = sched[t];
			end else begin
				w15 = sched[(t - 15) & 15];
				w2 = sched[(t - 2) & 15];
				w = sched[t & 15] + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
					+ sched[(t - 7) & 15] + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
				sched[t & 15] = w;
			end
			s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + sha256mh_pkg::RoundK[t] + w;
			s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + mj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < sha256mh_pkg::HashWords; i++) chain_h[i] = chain_h[i] + v[i];
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		sched[byte_pos[5:2]][(3 - byte_pos[1:0]) * 8 +: 8] = b;
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == 6'd0) compress_block();
	endtask

	task automatic hash_predict(input byte_word_t wd);
		logic [63:0]  len;
		logic [255:0] dig;
		if (wd.has_byte) begin
			bit_count = bit_count + 64'd8;
			absorb_byte(wd.data_byte);
		end
		if (wd.last) begin
			len = bit_count;
			absorb_byte(sha256mh_pkg::PadMark);
			while (byte_pos != 6'd56) absorb_byte(8'h00);
			for (int i = 7; i >= 0; i--) absorb_byte(len[8 * i +: 8]);
			for (int i = 0; i < sha256mh_pkg::HashWords; i++) dig[32 * i +: 32] = chain_h[i];
			digest_due = {digest_due, dig};
			restart_hash();
		end
	endtask

	task automatic queue_word(input logic [7:0] d, input logic has, input logic fin);
		pend_words = {pend_words, byte_word_t'{data_byte: d, has_byte: has, last: fin}};
	endtask

	task automatic queue_message(input int len);
		logic split;
		split = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) queue_word(8'($urandom), 1'b0, 1'b0);
			queue_word(8'($urandom), 1'b1, !split && (i == len - 1));
		end
		if (split) queue_word(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic log_miss(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch %s: expected %08h actual %08h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) hash_predict(shown_word);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pend_words.size() > 0) begin
					shown_word = pend_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= shown_word.data_byte;
					s_tuser <= shown_word.has_byte;
					s_tlast <= shown_word.last;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			m_tready <= !m_tready;
			ready_hold <= m_tready ? $urandom_range(0, 20) : $urandom_range(0, 30);
		end
	end

	always @(posedge clk) begin : digest_check
		logic [255:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_due.size() == 0) begin
				log_miss("digest word with none pending", '0, m_tdata[31:0]);
			end else begin
				want = digest_due.pop_front();
				for (int i = 0; i < sha256mh_pkg::HashWords; i++)
					if (m_tdata[32 * i +: 32] !== want[32 * i +: 32])
						log_miss($sformatf("digest_word_%0d", i), want[32 * i +: 32],
							m_tdata[32 * i +: 32]);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int r;
		int len;
		int edge_lens [8];
		edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
		restart_hash();
		for (int i = 0; i < 16; i++) sched[i] = '0;

		queue_word(8'h00, 1'b0, 1'b1);
		queue_word(8'hA5, 1'b0, 1'b0);
		queue_word(8'h00, 1'b1, 1'b1);
		queue_word(8'hFF, 1'b1, 1'b1);
		queue_word(8'h61, 1'b1, 1'b0);
		queue_word(8'h5A, 1'b0, 1'b0);
		queue_word(8'h62, 1'b1, 1'b0);
		queue_word(8'h63, 1'b1, 1'b1);
		queue_word(8'h5A, 1'b1, 1'b0);
		queue_word(8'hFF, 1'b0, 1'b1);
		queue_word(8'h80, 1'b0, 1'b0);
		queue_word(8'h01, 1'b1, 1'b0);
		queue_word(8'h7F, 1'b1, 1'b0);
		queue_word(8'hFE, 1'b1, 1'b1);

		while (pend_words.size() < WordTarget) begin
			r = $urandom_range(0, 99);
			if (r < 75) len = $urandom_range(0, 6);
			else if (r < 87) len = edge_lens[$urandom_range(0, 7)];
			else len = $urandom_range(7, 130);
			queue_message(len);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_words.size() != 0 || s_tvalid) @(negedge clk);
		while (digest_due.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (mismatches == 0 && digest_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
src/sha256mh_pkg.sv
src/sha256_message_hasher_core.sv
bench/tb.sv
